### rtl/tcmar_pkg.sv
`default_nettype none

package tcmar_pkg;

  localparam int WINDOW_LENGTH = 20;
  localparam int SAMPLE_BITS   = 12;
  localparam int NUM_CH        = 3;

  // transaction field widths
  localparam int IN_W      = 12;
  localparam int AVG_OUT_W = 12;
  localparam int DIST0_W   = 16;
  localparam int DIST_W    = 14;

  // register widths
  localparam int FSR_W  = 16;
  localparam int GAIN_W = 17;
  localparam int OFF_W  = 24;

  localparam int FSR_SHIFT = 12;
  localparam int Q_SHIFT   = 16;

  // APB
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_LENGTH);
  localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);

  // floor(sum / WINDOW_LENGTH) as (sum * DIV_M) >> DIV_S, exact for all sum < 2**SUM_W
  localparam int DIV_L  = $clog2(WINDOW_LENGTH);
  localparam int DIV_S  = SUM_W + DIV_L;
  localparam int DIV_MW = SUM_W + 1;
  localparam int DIV_PW = SUM_W + DIV_MW;
  localparam longint unsigned DIV_M =
    ((64'd1 << DIV_S) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
  localparam logic [DIV_MW-1:0] DIV_MC = DIV_MW'(DIV_M);

  localparam int P0_W  = SAMPLE_BITS + FSR_W;
  localparam int P12_W = SAMPLE_BITS + GAIN_W;
  localparam int DIFF_W = ((P12_W + 2) > (Q_SHIFT + DIST_W + 1)) ?
                          (P12_W + 2) : (Q_SHIFT + DIST_W + 1);
  localparam int QD_W   = DIFF_W - Q_SHIFT;

  localparam int DIST_MAX  = 2 ** (DIST_W - 1) - 1;
  localparam int DIST_MIN  = -(2 ** (DIST_W - 1));
  localparam int DIST0_MAX = 2 ** DIST0_W - 1;

  typedef enum logic [ADDR_W-3:0] {
    REG_FSR   = 3'd0,
    REG_GAIN1 = 3'd1,
    REG_OFF1  = 3'd2,
    REG_GAIN2 = 3'd3,
    REG_OFF2  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [FSR_W-1:0]  fsr;
    logic [GAIN_W-1:0] gain1;
    logic [OFF_W-1:0]  off1;
    logic [GAIN_W-1:0] gain2;
    logic [OFF_W-1:0]  off2;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    fsr:   16'd8570,
    gain1: 17'd66912,
    off1:  24'd7623392,
    gain2: 17'd67581,
    off2:  24'd4505237
  };

  typedef logic [NUM_CH-1:0][SAMPLE_BITS-1:0] avg_arr_t;

  // lane results toward the merge stage
  typedef struct packed {
    logic     valid;
    logic     full;
    avg_arr_t avg;
  } stage_a_t;

  function automatic logic [SAMPLE_BITS-1:0] win_avg(input logic [SUM_W-1:0] sum);
    logic [DIV_PW-1:0] p;
    p = DIV_PW'(sum) * DIV_PW'(DIV_MC);
    return p[DIV_S +: SAMPLE_BITS];
  endfunction

  function automatic logic [DIST0_W-1:0] dist0(input logic [P0_W-1:0] prod);
    logic [P0_W-FSR_SHIFT-1:0] sh;
    sh = prod[P0_W-1:FSR_SHIFT];
    if (32'(sh) > 32'(DIST0_MAX)) begin
      return DIST0_W'(DIST0_MAX);
    end
    return DIST0_W'(sh);
  endfunction

  // (prod - off) / 2**16 truncated toward zero, clamped to DIST_W signed
  function automatic logic signed [DIST_W-1:0] calib(input logic [P12_W-1:0] prod,
                                                     input logic [OFF_W-1:0] off);
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] diff_up;
    logic signed [DIFF_W-1:0] sel;
    logic signed [QD_W-1:0]   q;
    diff    = $signed(DIFF_W'(prod) - DIFF_W'(off));
    diff_up = $signed(DIFF_W'(prod) - DIFF_W'(off) + DIFF_W'((1 << Q_SHIFT) - 1));
    sel     = diff[DIFF_W-1] ? diff_up : diff;
    q       = sel[DIFF_W-1:Q_SHIFT];
    if (q > $signed(QD_W'(DIST_MAX))) begin
      return DIST_W'(DIST_MAX);
    end
    if (q < $signed(QD_W'(DIST_MIN))) begin
      return DIST_W'(DIST_MIN);
    end
    return q[DIST_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/tcmar_if.sv
`default_nettype none

interface tcmar_in_if;
  import tcmar_pkg::*;

  logic            valid;
  logic            ready;
  logic [IN_W-1:0] sample_ch0;
  logic [IN_W-1:0] sample_ch1;
  logic [IN_W-1:0] sample_ch2;

  modport source (output valid, sample_ch0, sample_ch1, sample_ch2, input ready);
  modport sink   (input valid, sample_ch0, sample_ch1, sample_ch2, output ready);
endinterface

interface tcmar_out_if;
  import tcmar_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [AVG_OUT_W-1:0]     average_ch0;
  logic [AVG_OUT_W-1:0]     average_ch1;
  logic [AVG_OUT_W-1:0]     average_ch2;
  logic [DIST0_W-1:0]       distance_ch0;
  logic signed [DIST_W-1:0] distance_ch1;
  logic signed [DIST_W-1:0] distance_ch2;
  logic                     window_full;

  modport source (output valid, average_ch0, average_ch1, average_ch2, distance_ch0,
                  distance_ch1, distance_ch2, window_full, input ready);
  modport sink   (input valid, average_ch0, average_ch1, average_ch2, distance_ch0,
                  distance_ch1, distance_ch2, window_full, output ready);
endinterface

`default_nettype wire

### rtl/tcmar_cfg.sv
`default_nettype none

module tcmar_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tcmar_pkg::ADDR_W-1:0] paddr,
  input  logic [tcmar_pkg::DATA_W-1:0] pwdata,
  output logic [tcmar_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output tcmar_pkg::cfg_t              cfg_o
);
  import tcmar_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (wr) begin
      case (idx)
        REG_FSR:   cfg_q.fsr   <= pwdata[FSR_W-1:0];
        REG_GAIN1: cfg_q.gain1 <= pwdata[GAIN_W-1:0];
        REG_OFF1:  cfg_q.off1  <= pwdata[OFF_W-1:0];
        REG_GAIN2: cfg_q.gain2 <= pwdata[GAIN_W-1:0];
        REG_OFF2:  cfg_q.off2  <= pwdata[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FSR:   prdata = DATA_W'(cfg_q.fsr);
      REG_GAIN1: prdata = DATA_W'(cfg_q.gain1);
      REG_OFF1:  prdata = DATA_W'(cfg_q.off1);
      REG_GAIN2: prdata = DATA_W'(cfg_q.gain2);
      REG_OFF2:  prdata = DATA_W'(cfg_q.off2);
      default:   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/tcmar_lane.sv
`default_nettype none

module tcmar_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              take_i,
  input  logic                              full_i,
  input  logic [tcmar_pkg::IN_W-1:0]        sample_i,
  output logic [tcmar_pkg::SAMPLE_BITS-1:0] avg_o
);
  import tcmar_pkg::*;

  logic [SAMPLE_BITS-1:0] win_q [WINDOW_LENGTH];
  logic [SAMPLE_BITS-1:0] s;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] avg_q, avg_d;

  assign s = SAMPLE_BITS'(sample_i);

  // oldest sample leaves once the window is full
  always_comb begin
    sum_d = sum_q + SUM_W'(s) - (full_i ? SUM_W'(win_q[WINDOW_LENGTH-1]) : '0);
    avg_d = full_i ? win_avg(sum_q) : avg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      avg_q <= '0;
    end else if (take_i) begin
      sum_q <= sum_d;
      avg_q <= avg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      win_q[0] <= s;
      for (int i = 1; i < WINDOW_LENGTH; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  assign avg_o = avg_q;

endmodule

`default_nettype wire

### rtl/tcmar_merge.sv
`default_nettype none

module tcmar_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tcmar_pkg::stage_a_t  sa_i,
  input  tcmar_pkg::cfg_t      cfg_i,
  output logic                 rdy_o,
  tcmar_out_if.source          out_o
);
  import tcmar_pkg::*;

  // product stage
  logic              vb_q;
  logic              fb_q;
  avg_arr_t          avgb_q;
  logic [P0_W-1:0]   p0_q;
  logic [P12_W-1:0]  p1_q;
  logic [P12_W-1:0]  p2_q;

  // output register
  logic                     ov_q;
  logic                     fo_q;
  avg_arr_t                 avgo_q;
  logic [DIST0_W-1:0]       d0_q;
  logic signed [DIST_W-1:0] d1_q;
  logic signed [DIST_W-1:0] d2_q;

  logic rdy_c;

  assign rdy_c = !ov_q || out_o.ready;
  assign rdy_o = !vb_q || rdy_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (rdy_o) begin
        vb_q <= sa_i.valid;
      end
      if (rdy_c) begin
        ov_q <= vb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && sa_i.valid) begin
      fb_q   <= sa_i.full;
      avgb_q <= sa_i.avg;
      p0_q   <= P0_W'(sa_i.avg[0]) * P0_W'(cfg_i.fsr);
      p1_q   <= P12_W'(sa_i.avg[1]) * P12_W'(cfg_i.gain1);
      p2_q   <= P12_W'(sa_i.avg[2]) * P12_W'(cfg_i.gain2);
    end
    if (rdy_c && vb_q) begin
      fo_q   <= fb_q;
      avgo_q <= avgb_q;
      d0_q   <= dist0(p0_q);
      d1_q   <= calib(p1_q, cfg_i.off1);
      d2_q   <= calib(p2_q, cfg_i.off2);
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.average_ch0  = AVG_OUT_W'(avgo_q[0]);
  assign out_o.average_ch1  = AVG_OUT_W'(avgo_q[1]);
  assign out_o.average_ch2  = AVG_OUT_W'(avgo_q[2]);
  assign out_o.distance_ch0 = d0_q;
  assign out_o.distance_ch1 = d1_q;
  assign out_o.distance_ch2 = d2_q;
  assign out_o.window_full  = fo_q;

endmodule

`default_nettype wire

### rtl/three_channel_moving_average_ranger.sv
// Three-channel moving-average ranger.
// in_i carries one triple of converter samples per transaction; out_o returns
// one result per input: the three held window averages, the calibrated
// distances and window_full. Both channels use valid/ready.
// Three identical lanes each hold a 20-sample shift line, a running sum and
// the held average; a merge stage multiplies the averages by the registered
// calibration (APB port, registers at byte addresses 0,4,...,16) and applies
// offset, truncation and clamping.
// Each result is registered in the lane stage, the product stage and the output register.
// Throughput: one transaction per cycle unless out_o stalls; the lane update
// (sum, shift line, constant-reciprocal divide) completes at the edge that takes a sample.
// Reset clears sums, held averages, fill count and pipeline valids; the
// configuration returns to its defaults. No clearing pass is needed.
// When out_o is stalled the result holds in the output register and the two
// earlier stages still fill, so up to three transactions are in flight before
// in_i.ready drops.
`default_nettype none

module three_channel_moving_average_ranger (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tcmar_in_if.sink                     in_i,
  tcmar_out_if.source                  out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tcmar_pkg::ADDR_W-1:0] paddr,
  input  logic [tcmar_pkg::DATA_W-1:0] pwdata,
  output logic [tcmar_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);
  import tcmar_pkg::*;

  cfg_t                        cfg;
  logic [NUM_CH-1:0][IN_W-1:0] samples;
  avg_arr_t                    avg_a;
  stage_a_t                    sa;
  logic                        accept;
  logic                        rdy_b;
  logic                        full;
  logic                        va_q;
  logic                        fa_q;
  logic [FILL_W-1:0]           fill_q, fill_d;

  assign samples[0] = in_i.sample_ch0;
  assign samples[1] = in_i.sample_ch1;
  assign samples[2] = in_i.sample_ch2;

  assign in_i.ready = !va_q || rdy_b;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (fill_q == FILL_W'(WINDOW_LENGTH));
  assign fill_d     = full ? fill_q : fill_q + FILL_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      va_q   <= 1'b0;
      fa_q   <= 1'b0;
    end else begin
      va_q <= accept || (va_q && !rdy_b);
      if (accept) begin
        fill_q <= fill_d;
        fa_q   <= (fill_d == FILL_W'(WINDOW_LENGTH));
      end
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    tcmar_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .take_i   (accept),
      .full_i   (full),
      .sample_i (samples[c]),
      .avg_o    (avg_a[c])
    );
  end

  assign sa.valid = va_q;
  assign sa.full  = fa_q;
  assign sa.avg   = avg_a;

  tcmar_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sa_i   (sa),
    .cfg_i  (cfg),
    .rdy_o  (rdy_b),
    .out_o  (out_o)
  );

  tcmar_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

endmodule

`default_nettype wire

### rtl/tcmar_checker.sv
`default_nettype none

module tcmar_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [tcmar_pkg::AVG_OUT_W-1:0]     avg0_i,
  input  logic [tcmar_pkg::AVG_OUT_W-1:0]     avg1_i,
  input  logic [tcmar_pkg::AVG_OUT_W-1:0]     avg2_i,
  input  logic [tcmar_pkg::DIST0_W-1:0]       dist0_i,
  input  logic signed [tcmar_pkg::DIST_W-1:0] dist1_i,
  input  logic signed [tcmar_pkg::DIST_W-1:0] dist2_i,
  input  logic                                full_i
);
  import tcmar_pkg::*;

  logic [2:0] pend_q;
  logic       seen_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      seen_q <= 1'b0;
    end else begin
      pend_q <= pend_q + 3'(in_acc) - 3'(out_acc);
      if (out_acc && full_i) begin
        seen_q <= 1'b1;
      end
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(avg0_i) && $stable(avg1_i) &&
      $stable(avg2_i) && $stable(dist0_i) && $stable(dist1_i) && $stable(dist2_i) &&
      $stable(full_i))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 3'd0)
    else $error("result without a pending transaction");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("more transactions in flight than pipeline stages");

  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seen_q |-> full_i)
    else $error("window_full dropped after being set");

  a_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !full_i |-> avg0_i == '0 && avg1_i == '0 && avg2_i == '0 &&
      dist0_i == '0)
    else $error("nonzero average while window fills");

endmodule

bind three_channel_moving_average_ranger tcmar_checker u_tcmar_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .avg0_i      (out_o.average_ch0),
  .avg1_i      (out_o.average_ch1),
  .avg2_i      (out_o.average_ch2),
  .dist0_i     (out_o.distance_ch0),
  .dist1_i     (out_o.distance_ch1),
  .dist2_i     (out_o.distance_ch2),
  .full_i      (out_o.window_full)
);

`default_nettype wire

### sim/three_channel_moving_average_ranger_tb.sv
`default_nettype none

module three_channel_moving_average_ranger_tb;
  import tcmar_pkg::*;

  typedef struct packed {
    logic [AVG_OUT_W-1:0]     average_ch0;
    logic [AVG_OUT_W-1:0]     average_ch1;
    logic [AVG_OUT_W-1:0]     average_ch2;
    logic [DIST0_W-1:0]       distance_ch0;
    logic signed [DIST_W-1:0] distance_ch1;
    logic signed [DIST_W-1:0] distance_ch2;
    logic                     window_full;
  } ranger_result_t;

  class ranger_scoreboard;
    bit [SAMPLE_BITS-1:0] window_mem [WINDOW_LENGTH][NUM_CH];
    int unsigned          fill_cnt;
    int unsigned          oldest;
    int unsigned          sums [NUM_CH];
    int unsigned          held [NUM_CH];
    cfg_t                 cfg;
    ranger_result_t       expected_q [$];
    int                   errors;

    function new();
      fill_cnt = 0;
      oldest   = 0;
      errors   = 0;
      cfg      = CFG_RST;
      for (int c = 0; c < NUM_CH; c++) begin
        sums[c] = 0;
        held[c] = 0;
      end
    endfunction

    function void write_reg(int idx, logic [DATA_W-1:0] v);
      case (idx)
        REG_FSR:   cfg.fsr   = v[FSR_W-1:0];
        REG_GAIN1: cfg.gain1 = v[GAIN_W-1:0];
        REG_OFF1:  cfg.off1  = v[OFF_W-1:0];
        REG_GAIN2: cfg.gain2 = v[GAIN_W-1:0];
        REG_OFF2:  cfg.off2  = v[OFF_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] reg_value(int idx);
      case (idx)
        REG_FSR:   return DATA_W'(cfg.fsr);
        REG_GAIN1: return DATA_W'(cfg.gain1);
        REG_OFF1:  return DATA_W'(cfg.off1);
        REG_GAIN2: return DATA_W'(cfg.gain2);
        REG_OFF2:  return DATA_W'(cfg.off2);
        default:   return '0;
      endcase
    endfunction

    // truncate toward zero, clamp to the signed distance range
    function logic signed [DIST_W-1:0] calibrated(int unsigned avg, logic [GAIN_W-1:0] gain,
                                                  logic [OFF_W-1:0] off);
      longint diff;
      longint mag;
      diff = longint'(avg) * longint'(gain) - longint'(off);
      if (diff >= 0) begin
        mag = diff >>> Q_SHIFT;
        if (mag > DIST_MAX) mag = DIST_MAX;
        return DIST_W'(mag);
      end
      mag = (-diff) >>> Q_SHIFT;
      if (mag > -DIST_MIN) mag = -DIST_MIN;
      return DIST_W'(-mag);
    endfunction

    function void note_sample(logic [IN_W-1:0] s0, logic [IN_W-1:0] s1, logic [IN_W-1:0] s2);
      bit [SAMPLE_BITS-1:0] s [NUM_CH];
      ranger_result_t       r;
      longint               d0;
      s[0] = s0;
      s[1] = s1;
      s[2] = s2;
      if (fill_cnt < WINDOW_LENGTH) begin
        for (int c = 0; c < NUM_CH; c++) begin
          window_mem[fill_cnt][c] = s[c];
          sums[c] += s[c];
        end
        fill_cnt++;
      end else begin
        for (int c = 0; c < NUM_CH; c++) begin
          held[c] = sums[c] / WINDOW_LENGTH;
          sums[c] -= window_mem[oldest][c];
          window_mem[oldest][c] = s[c];
          sums[c] += s[c];
        end
        oldest = (oldest + 1) % WINDOW_LENGTH;
      end
      r.average_ch0 = AVG_OUT_W'(held[0]);
      r.average_ch1 = AVG_OUT_W'(held[1]);
      r.average_ch2 = AVG_OUT_W'(held[2]);
      d0 = (longint'(held[0]) * longint'(cfg.fsr)) >>> FSR_SHIFT;
      if (d0 > DIST0_MAX) d0 = DIST0_MAX;
      r.distance_ch0 = DIST0_W'(d0);
      r.distance_ch1 = calibrated(held[1], cfg.gain1, cfg.off1);
      r.distance_ch2 = calibrated(held[2], cfg.gain2, cfg.off2);
      r.window_full  = (fill_cnt >= WINDOW_LENGTH);
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, longint e, longint a);
      if (e != a) begin
        $error("%s expected %0d actual %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(ranger_result_t act);
      ranger_result_t e;
      if (expected_q.size() == 0) begin
        $error("result transaction with no pending input");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("average_ch0", e.average_ch0, act.average_ch0);
      compare_field("average_ch1", e.average_ch1, act.average_ch1);
      compare_field("average_ch2", e.average_ch2, act.average_ch2);
      compare_field("distance_ch0", e.distance_ch0, act.distance_ch0);
      compare_field("distance_ch1", longint'($signed(e.distance_ch1)),
                    longint'($signed(act.distance_ch1)));
      compare_field("distance_ch2", longint'($signed(e.distance_ch2)),
                    longint'($signed(act.distance_ch2)));
      compare_field("window_full", e.window_full, act.window_full);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  tcmar_in_if  in_bus ();
  tcmar_out_if out_bus ();

  three_channel_moving_average_ranger u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ranger_scoreboard sb = new();
  int idle_pct  = 0;
  int stall_pct = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    ranger_result_t act;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        sb.note_sample(in_bus.sample_ch0, in_bus.sample_ch1, in_bus.sample_ch2);
      end
      if (out_bus.valid && out_bus.ready) begin
        act.average_ch0  = out_bus.average_ch0;
        act.average_ch1  = out_bus.average_ch1;
        act.average_ch2  = out_bus.average_ch2;
        act.distance_ch0 = out_bus.distance_ch0;
        act.distance_ch1 = out_bus.distance_ch1;
        act.distance_ch2 = out_bus.distance_ch2;
        act.window_full  = out_bus.window_full;
        sb.check_result(act);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_triple(logic [IN_W-1:0] s0, logic [IN_W-1:0] s1, logic [IN_W-1:0] s2);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.sample_ch0 <= s0;
    in_bus.sample_ch1 <= s1;
    in_bus.sample_ch2 <= s2;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic program_reg(int idx, logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx <= int'(REG_OFF2)) begin
      @(negedge clk_i);
      psel   <= 1'b1;
      pwrite <= 1'b0;
      @(negedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      rd = prdata;
      if (rd !== sb.reg_value(idx)) begin
        $error("prdata of register %0d expected %0h actual %0h", idx, sb.reg_value(idx), rd);
        sb.errors++;
      end
      @(negedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
    // leave the bus idle between transfers
    @(negedge clk_i);
  endtask

  function automatic logic [IN_W-1:0] pick_sample(int style);
    case (style)
      0:       return IN_W'($urandom_range(0, 4095));
      1:       return ($urandom_range(0, 7) == 0) ? IN_W'($urandom) : '1;
      2:       return ($urandom_range(0, 7) == 0) ? IN_W'($urandom) : '0;
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  initial begin
    cfg_t c;
    int   style;
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_bus.valid      = 1'b0;
    in_bus.sample_ch0 = '0;
    in_bus.sample_ch1 = '0;
    in_bus.sample_ch2 = '0;
    out_bus.ready     = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // window fill at reset calibration, then full-scale averages
    for (int i = 0; i < 20; i++) begin
      case (i)
        5:       send_triple(12'hAAA, 12'h555, 12'hAAA);
        6:       send_triple(12'h555, 12'hAAA, 12'h555);
        default: send_triple('1, '1, '0);
      endcase
    end
    for (int i = 0; i < 5; i++) send_triple('0, '1, '1);
    drain();

    for (int p = 0; p < 9; p++) begin
      if (p == 0) begin
        for (int r = 0; r <= int'(REG_OFF2); r++) program_reg(r, 32'hFFFF_FFFF);
      end else begin
        case (p)
          1: c = '0;
          2: c = CFG_RST;
          3: c = '{fsr: '1, gain1: '1, off1: '0, gain2: '1, off2: '0};
          4: c = '{fsr: 16'd1, gain1: '0, off1: '1, gain2: '0, off2: '1};
          default: begin
            c.fsr   = FSR_W'($urandom);
            c.gain1 = GAIN_W'($urandom);
            c.off1  = OFF_W'($urandom);
            c.gain2 = GAIN_W'($urandom);
            c.off2  = OFF_W'($urandom);
          end
        endcase
        program_reg(REG_FSR, DATA_W'(c.fsr));
        program_reg(REG_GAIN1, DATA_W'(c.gain1));
        program_reg(REG_OFF1, DATA_W'(c.off1));
        program_reg(REG_GAIN2, DATA_W'(c.gain2));
        program_reg(REG_OFF2, DATA_W'(c.off2));
      end
      // unmapped index, must leave the calibration alone
      program_reg($urandom_range(int'(REG_OFF2) + 1, 7), $urandom);

      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase

      style = 0;
      for (int k = 0; k < 100; k++) begin
        if (k % 25 == 0) style = $urandom_range(0, 3);
        if (k == 50 && p % 2 == 1) drain();
        send_triple(pick_sample(style), pick_sample(style), pick_sample(style));
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
